// File: hdl/zbuffer_triangle_rasterizer_core_macros.svh
// assertion macros used by the rasterizer core rtl
`ifndef ZBUFFER_TRIANGLE_RASTERIZER_CORE_MACROS_SVH
`define ZBUFFER_TRIANGLE_RASTERIZER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define ZTR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ZTR_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ZTR_ASSERT(lbl, prop, msg)
`define ZTR_NEVER(lbl, cond, msg)
`endif
`endif

// File: hdl/ztr_pkg.sv
// shared types and constants of the z-buffer triangle rasterizer
`default_nettype none
package ztr_pkg;
	localparam int MAX_WIDTH     = 256;
	localparam int MAX_HEIGHT    = 256;
	localparam int MAX_TRIANGLES = 65536;
	localparam int CHANNELS      = 3;
	localparam int CH_MAX        = (CHANNELS < 3) ? CHANNELS : 3;
	localparam int NPIX          = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W        = $clog2(NPIX);
	localparam int XW            = $clog2(MAX_WIDTH);
	localparam int YW            = $clog2(MAX_HEIGHT);
	localparam int CW            = (XW > YW) ? XW : YW;
	localparam int TRI_W         = $clog2(MAX_TRIANGLES);
	localparam int DEPTH_W       = 32;
	localparam int COL_W         = 24;
	localparam int TIDX_W        = 17;
	localparam int DW            = 64;
	localparam int MB            = 40;
	localparam int NW            = 40;
	localparam int CFG_IDX_W     = 3;

	localparam logic [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};
	localparam logic [TIDX_W-1:0]  TIDX_NONE = {TIDX_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FLAT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CWE      = 3'd4;

	typedef enum logic [1:0] {
		MODE_BG    = 2'd0,
		MODE_VERT  = 2'd1,
		MODE_READ  = 2'd2,
		MODE_FRAME = 2'd3
	} mode_t;

	typedef enum logic {
		MDU_MUL = 1'b0,
		MDU_DIV = 1'b1
	} mdu_op_t;

	typedef struct packed {
		logic    start;
		mdu_op_t op;
	} mdu_ctl_t;

	typedef struct packed {
		logic              we;
		logic              col_en;
		logic [ADDR_W-1:0] addr;
		logic [DEPTH_W-1:0] depth;
		logic [TIDX_W-1:0] tidx;
		logic [COL_W-1:0]  col;
	} fb_wr_t;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] addr;
	} fb_rd_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_RD_OUT, ST_SETUP, ST_DET_A, ST_DET_B, ST_DET_CHK,
		ST_N0_A, ST_N0_B, ST_N1_A, ST_N1_B, ST_COVER, ST_Z0, ST_Z1, ST_Z2,
		ST_ZDIV, ST_MEM_RD, ST_MEM_CMP, ST_C0, ST_C1, ST_C2, ST_CDIV,
		ST_PIX_WR, ST_PIX_NEXT, ST_TRI_END
	} ztr_state_t;
endpackage
`default_nettype wire

// File: hdl/ztr_mdu.sv
// shared iterative multiply-accumulate and floor-divide unit
`default_nettype none
module ztr_mdu (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire ztr_pkg::mdu_ctl_t                ctl,
	input  wire logic signed [ztr_pkg::DW-1:0]    a,
	input  wire logic signed [ztr_pkg::DW-1:0]    b,
	input  wire logic signed [ztr_pkg::DW-1:0]    acc,
	output logic                                  busy,
	output logic                                  done,
	output logic signed [ztr_pkg::DW-1:0]         res
);
	logic                          run_q, fin_q, done_q, neg_q;
	ztr_pkg::mdu_op_t              op_q;
	logic signed [ztr_pkg::DW-1:0] p_q, mc_q;
	logic [ztr_pkg::MB-1:0]        mp_q;
	logic [ztr_pkg::DW-1:0]        quo_q, rem_q, dvs_q, rs;
	logic [ztr_pkg::DW:0]          diff;
	logic [$clog2(ztr_pkg::DW)-1:0] cnt_q;

	assign rs   = {rem_q[ztr_pkg::DW-2:0], quo_q[ztr_pkg::DW-1]};
	assign diff = {1'b0, rs} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				op_q  <= ctl.op;
				run_q <= 1'b1;
				fin_q <= 1'b0;
				cnt_q <= '0;
				if (ctl.op == ztr_pkg::MDU_MUL) begin
					p_q  <= acc;
					mc_q <= b[ztr_pkg::DW-1] ? -a : a;
					mp_q <= ztr_pkg::MB'(b[ztr_pkg::DW-1] ? -b : b);
				end else begin
					quo_q <= a[ztr_pkg::DW-1] ? -a : a;
					rem_q <= '0;
					dvs_q <= b;
					neg_q <= a[ztr_pkg::DW-1];
				end
			end else if (run_q) begin
				if (op_q == ztr_pkg::MDU_MUL) begin
					if (mp_q == '0) begin
						res    <= p_q;
						run_q  <= 1'b0;
						done_q <= 1'b1;
					end else begin
						if (mp_q[0]) begin
							p_q <= p_q + mc_q;
						end
						mc_q <= mc_q <<< 1;
						mp_q <= mp_q >> 1;
					end
				end else if (fin_q) begin
					// floor for negative dividends: -q, or ~q when a remainder is left
					res    <= neg_q ? $signed(~quo_q + ztr_pkg::DW'(rem_q == '0))
					                : $signed(quo_q);
					run_q  <= 1'b0;
					fin_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					if (!diff[ztr_pkg::DW]) begin
						rem_q <= diff[ztr_pkg::DW-1:0];
						quo_q <= {quo_q[ztr_pkg::DW-2:0], 1'b1};
					end else begin
						rem_q <= rs;
						quo_q <= {quo_q[ztr_pkg::DW-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '1) begin
						fin_q <= 1'b1;
					end
				end
			end
		end
	end

	assign busy = run_q;
	assign done = done_q;
endmodule
`default_nettype wire

// File: hdl/ztr_fbuf.sv
// frame stores for depth, colour and triangle index
`default_nettype none
module ztr_fbuf (
	input  wire logic                               clk,
	input  wire ztr_pkg::fb_wr_t                    wr,
	input  wire ztr_pkg::fb_rd_t                    rd,
	output logic signed [ztr_pkg::DEPTH_W-1:0]      rd_depth,
	output logic [ztr_pkg::TIDX_W-1:0]              rd_tidx,
	output logic [ztr_pkg::COL_W-1:0]               rd_col
);
	logic [ztr_pkg::DEPTH_W-1:0] depth_mem [ztr_pkg::NPIX];
	logic [ztr_pkg::TIDX_W-1:0]  tidx_mem  [ztr_pkg::NPIX];
	logic [ztr_pkg::COL_W-1:0]   col_mem   [ztr_pkg::NPIX];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			depth_mem[wr.addr] <= wr.depth;
			tidx_mem[wr.addr]  <= wr.tidx;
			if (wr.col_en) begin
				col_mem[wr.addr] <= wr.col;
			end
		end
		if (rd.re) begin
			rd_depth <= $signed(depth_mem[rd.addr]);
			rd_tidx  <= tidx_mem[rd.addr];
			rd_col   <= col_mem[rd.addr];
		end
	end
endmodule
`default_nettype wire

// File: hdl/zbuffer_triangle_rasterizer_core.sv
// Depth-buffered triangle rasterizer core. After reset the core sweeps the depth and
// triangle-index stores once, one pixel a cycle, and takes no item until done;
// configuration writes are taken at any time. A background write, a vertex that is not
// the third and a new-frame beat are handled in the idle state itself; a read result
// passes through the store's read register into the output register and waits there
// until taken. A third vertex draws a triangle with one shared multiply-accumulate /
// divide unit: a multiply steps once per significant bit of the magnitude of its
// second operand, a divide once per bit of its 64-bit dividend. Every pixel of the
// clamped bounding box costs four multiplies; a covered pixel adds three depth
// multiplies, a divide and a store read, and a pixel that wins the depth test adds per
// colour channel three short multiplies and a divide when colour is interpolated.
// In/out beats use valid/ready; a read that finds an earlier result still untaken
// waits for it to be taken, and no further item is accepted meanwhile.
`default_nettype none
`include "zbuffer_triangle_rasterizer_core_macros.svh"
module zbuffer_triangle_rasterizer_core (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [1:0]               mode,
	input  wire logic signed [15:0]       vert_x,
	input  wire logic signed [15:0]       vert_y,
	input  wire logic signed [23:0]       vert_z,
	input  wire logic [7:0]               chan_a,
	input  wire logic [7:0]               chan_b,
	input  wire logic [7:0]               chan_c,
	input  wire logic [7:0]               pixel_x,
	input  wire logic [7:0]               pixel_y,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [31:0]            read_depth,
	output logic [7:0]                    read_chan_a,
	output logic [7:0]                    read_chan_b,
	output logic [7:0]                    read_chan_c,
	output logic signed [16:0]            read_triangle,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [ztr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [8:0]               cfg_data
);
	localparam int DW = ztr_pkg::DW;
	localparam int NW = ztr_pkg::NW;

	// control
	ztr_pkg::ztr_state_t state_q, state_d;
	logic                issued_q;
	logic                op_state;
	logic                accept;
	ztr_pkg::mode_t      mode_in;

	// configuration
	logic [8:0] width_q, height_q;
	logic [1:0] chan_q;
	logic       flat_q, cwe_q;
	logic [8:0] weff, heff;
	logic [1:0] nch;

	// vertices and frame bookkeeping
	logic signed [15:0] vx_q [3];
	logic signed [15:0] vy_q [3];
	logic signed [23:0] vz_q [3];
	logic [23:0]        vc_q [3];
	logic [1:0]         phase_q;
	logic [ztr_pkg::TRI_W-1:0] count_q;
	logic [ztr_pkg::ADDR_W-1:0] clr_q;

	// triangle setup
	logic signed [15:0] mnx, mxx, mny, mxy;
	logic signed [16:0] e0a_q, e0b_q, e1a_q, e1b_q, dy02_q;
	logic [ztr_pkg::XW-1:0] x0_q, x1_q, x_q;
	logic [ztr_pkg::YW-1:0] y0_q, y1_q, y_q;
	logic signed [NW-1:0] det_q, n0_q, n1_q, n2_q, n2_c, res_n;
	logic                 neg_q;
	logic signed [18:0]   dx, dy;
	logic signed [31:0]   z_q;
	logic [23:0]          col_q, flat_col;
	logic [1:0]           ch_q;
	logic [7:0]           csel0, csel1, csel2;

	// math unit
	ztr_pkg::mdu_ctl_t    mdu_ctl;
	logic signed [DW-1:0] mdu_a, mdu_b, mdu_acc, mdu_res;
	logic                 mdu_busy, mdu_done;

	// stores
	ztr_pkg::fb_wr_t            fb_wr;
	ztr_pkg::fb_rd_t            fb_rd;
	logic signed [31:0]         rd_depth;
	logic [16:0]                rd_tidx;
	logic [23:0]                rd_col;
	logic                       pix_in, rd_in_q;
	logic [ztr_pkg::ADDR_W-1:0] pix_addr, tri_addr;
	logic                       out_load;

	function automatic logic [ztr_pkg::CW-1:0] clampc(input logic signed [17:0] v,
		input logic signed [17:0] hi);
		if (v < 18'sd0) begin
			return '0;
		end else if (v > hi) begin
			return ztr_pkg::CW'(hi);
		end
		return ztr_pkg::CW'(v);
	endfunction

	assign mode_in  = ztr_pkg::mode_t'(mode);
	assign accept   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// effective register values, saturated to the supported range
	always_comb begin
		weff = width_q;
		if (width_q == 9'd0) begin
			weff = 9'd1;
		end else if (32'(width_q) > ztr_pkg::MAX_WIDTH) begin
			weff = 9'(ztr_pkg::MAX_WIDTH);
		end
		heff = height_q;
		if (height_q == 9'd0) begin
			heff = 9'd1;
		end else if (32'(height_q) > ztr_pkg::MAX_HEIGHT) begin
			heff = 9'(ztr_pkg::MAX_HEIGHT);
		end
		nch = chan_q;
		if (chan_q == 2'd0) begin
			nch = 2'd1;
		end else if (32'(chan_q) > ztr_pkg::CH_MAX) begin
			nch = 2'(ztr_pkg::CH_MAX);
		end
	end

	assign pix_in   = (32'(pixel_x) < ztr_pkg::MAX_WIDTH) &&
	                  (32'(pixel_y) < ztr_pkg::MAX_HEIGHT);
	assign pix_addr = ztr_pkg::ADDR_W'(pixel_y) * ztr_pkg::ADDR_W'(ztr_pkg::MAX_WIDTH)
	                + ztr_pkg::ADDR_W'(pixel_x);
	assign tri_addr = ztr_pkg::ADDR_W'(y_q) * ztr_pkg::ADDR_W'(ztr_pkg::MAX_WIDTH)
	                + ztr_pkg::ADDR_W'(x_q);

	// bounding box of the three held vertices
	always_comb begin
		mnx = vx_q[0];
		mxx = vx_q[0];
		mny = vy_q[0];
		mxy = vy_q[0];
		for (int i = 1; i < 3; i++) begin
			if (vx_q[i] < mnx) mnx = vx_q[i];
			if (vx_q[i] > mxx) mxx = vx_q[i];
			if (vy_q[i] < mny) mny = vy_q[i];
			if (vy_q[i] > mxy) mxy = vy_q[i];
		end
	end

	// sample point relative to the third vertex
	assign dx = $signed(19'({x_q, 4'b0000})) - 19'(vx_q[2]);
	assign dy = $signed(19'({y_q, 4'b0000})) - 19'(vy_q[2]);

	assign res_n = mdu_res[NW-1:0];
	assign n2_c  = det_q - n0_q - n1_q;
	assign csel0 = vc_q[0][{ch_q, 3'b000} +: 8];
	assign csel1 = vc_q[1][{ch_q, 3'b000} +: 8];
	assign csel2 = vc_q[2][{ch_q, 3'b000} +: 8];

	// flat colour merged over the stored word for the active channels
	always_comb begin
		flat_col = rd_col;
		for (int c = 0; c < 3; c++) begin
			if (c < int'(nch)) begin
				flat_col[8*c +: 8] = vc_q[0][8*c +: 8];
			end
		end
	end

	// states that run the shared unit
	always_comb begin
		unique case (state_q)
			ztr_pkg::ST_DET_A, ztr_pkg::ST_DET_B, ztr_pkg::ST_N0_A, ztr_pkg::ST_N0_B,
			ztr_pkg::ST_N1_A, ztr_pkg::ST_N1_B, ztr_pkg::ST_Z0, ztr_pkg::ST_Z1,
			ztr_pkg::ST_Z2, ztr_pkg::ST_ZDIV, ztr_pkg::ST_C0, ztr_pkg::ST_C1,
			ztr_pkg::ST_C2, ztr_pkg::ST_CDIV: op_state = 1'b1;
			default: op_state = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ztr_pkg::ST_CLEAR: begin
				if (clr_q == ztr_pkg::ADDR_W'(ztr_pkg::NPIX - 1)) state_d = ztr_pkg::ST_IDLE;
			end
			ztr_pkg::ST_IDLE: begin
				if (accept) begin
					if (mode_in == ztr_pkg::MODE_READ) begin
						state_d = ztr_pkg::ST_RD_OUT;
					end else if (mode_in == ztr_pkg::MODE_VERT && phase_q == 2'd2) begin
						state_d = ztr_pkg::ST_SETUP;
					end
				end
			end
			ztr_pkg::ST_RD_OUT: begin
				if (!out_valid || out_ready) state_d = ztr_pkg::ST_IDLE;
			end
			ztr_pkg::ST_SETUP: state_d = ztr_pkg::ST_DET_A;
			ztr_pkg::ST_DET_A: if (mdu_done) state_d = ztr_pkg::ST_DET_B;
			ztr_pkg::ST_DET_B: if (mdu_done) state_d = ztr_pkg::ST_DET_CHK;
			ztr_pkg::ST_DET_CHK: begin
				// zero area or a box clamped away: nothing drawn
				if (det_q == '0 || x0_q > x1_q || y0_q > y1_q) begin
					state_d = ztr_pkg::ST_TRI_END;
				end else begin
					state_d = ztr_pkg::ST_N0_A;
				end
			end
			ztr_pkg::ST_N0_A: if (mdu_done) state_d = ztr_pkg::ST_N0_B;
			ztr_pkg::ST_N0_B: if (mdu_done) state_d = ztr_pkg::ST_N1_A;
			ztr_pkg::ST_N1_A: if (mdu_done) state_d = ztr_pkg::ST_N1_B;
			ztr_pkg::ST_N1_B: if (mdu_done) state_d = ztr_pkg::ST_COVER;
			ztr_pkg::ST_COVER: begin
				if (n0_q < 0 || n1_q < 0 || n2_c < 0) begin
					state_d = ztr_pkg::ST_PIX_NEXT;
				end else begin
					state_d = ztr_pkg::ST_Z0;
				end
			end
			ztr_pkg::ST_Z0:   if (mdu_done) state_d = ztr_pkg::ST_Z1;
			ztr_pkg::ST_Z1:   if (mdu_done) state_d = ztr_pkg::ST_Z2;
			ztr_pkg::ST_Z2:   if (mdu_done) state_d = ztr_pkg::ST_ZDIV;
			ztr_pkg::ST_ZDIV: if (mdu_done) state_d = ztr_pkg::ST_MEM_RD;
			ztr_pkg::ST_MEM_RD: state_d = ztr_pkg::ST_MEM_CMP;
			ztr_pkg::ST_MEM_CMP: begin
				if (!(rd_depth < z_q)) begin
					state_d = ztr_pkg::ST_PIX_NEXT;
				end else if (cwe_q && !flat_q) begin
					state_d = ztr_pkg::ST_C0;
				end else begin
					state_d = ztr_pkg::ST_PIX_WR;
				end
			end
			ztr_pkg::ST_C0: if (mdu_done) state_d = ztr_pkg::ST_C1;
			ztr_pkg::ST_C1: if (mdu_done) state_d = ztr_pkg::ST_C2;
			ztr_pkg::ST_C2: if (mdu_done) state_d = ztr_pkg::ST_CDIV;
			ztr_pkg::ST_CDIV: begin
				if (mdu_done) begin
					state_d = (ch_q == nch - 2'd1) ? ztr_pkg::ST_PIX_WR : ztr_pkg::ST_C0;
				end
			end
			ztr_pkg::ST_PIX_WR: state_d = ztr_pkg::ST_PIX_NEXT;
			ztr_pkg::ST_PIX_NEXT: begin
				if (x_q == x1_q && y_q == y1_q) begin
					state_d = ztr_pkg::ST_TRI_END;
				end else begin
					state_d = ztr_pkg::ST_N0_A;
				end
			end
			ztr_pkg::ST_TRI_END: state_d = ztr_pkg::ST_IDLE;
			default: state_d = ztr_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer: handshake, unit operands, store ports
	always_comb begin
		in_ready    = (state_q == ztr_pkg::ST_IDLE);
		mdu_ctl.start = op_state && !issued_q;
		mdu_ctl.op  = ztr_pkg::MDU_MUL;
		mdu_a       = '0;
		mdu_b       = '0;
		mdu_acc     = '0;
		fb_wr       = '0;
		fb_rd       = '0;
		out_load    = (state_q == ztr_pkg::ST_RD_OUT) && (!out_valid || out_ready);
		unique case (state_q)
			ztr_pkg::ST_DET_A: begin
				mdu_a = DW'(e0a_q);
				mdu_b = DW'(e1b_q);
			end
			ztr_pkg::ST_DET_B: begin
				mdu_a   = DW'(e0b_q);
				mdu_b   = DW'(dy02_q);
				mdu_acc = mdu_res;
			end
			ztr_pkg::ST_N0_A: begin
				mdu_a = DW'(e0a_q);
				mdu_b = DW'(dx);
			end
			ztr_pkg::ST_N0_B: begin
				mdu_a   = DW'(e0b_q);
				mdu_b   = DW'(dy);
				mdu_acc = mdu_res;
			end
			ztr_pkg::ST_N1_A: begin
				mdu_a = DW'(e1a_q);
				mdu_b = DW'(dx);
			end
			ztr_pkg::ST_N1_B: begin
				mdu_a   = DW'(e1b_q);
				mdu_b   = DW'(dy);
				mdu_acc = mdu_res;
			end
			// numerator 2*sum + det gives round half up after floor division by 2*det
			ztr_pkg::ST_Z0: begin
				mdu_a   = DW'(n0_q) <<< 1;
				mdu_b   = DW'(vz_q[0]);
				mdu_acc = DW'(det_q);
			end
			ztr_pkg::ST_Z1: begin
				mdu_a   = DW'(n1_q) <<< 1;
				mdu_b   = DW'(vz_q[1]);
				mdu_acc = mdu_res;
			end
			ztr_pkg::ST_Z2: begin
				mdu_a   = DW'(n2_q) <<< 1;
				mdu_b   = DW'(vz_q[2]);
				mdu_acc = mdu_res;
			end
			ztr_pkg::ST_ZDIV, ztr_pkg::ST_CDIV: begin
				mdu_ctl.op = ztr_pkg::MDU_DIV;
				mdu_a      = mdu_res;
				mdu_b      = DW'(det_q) <<< 1;
			end
			ztr_pkg::ST_C0: begin
				mdu_a   = DW'(n0_q) <<< 1;
				mdu_b   = DW'(csel0);
				mdu_acc = DW'(det_q);
			end
			ztr_pkg::ST_C1: begin
				mdu_a   = DW'(n1_q) <<< 1;
				mdu_b   = DW'(csel1);
				mdu_acc = mdu_res;
			end
			ztr_pkg::ST_C2: begin
				mdu_a   = DW'(n2_q) <<< 1;
				mdu_b   = DW'(csel2);
				mdu_acc = mdu_res;
			end
			ztr_pkg::ST_CLEAR: begin
				fb_wr.we    = 1'b1;
				fb_wr.addr  = clr_q;
				fb_wr.depth = ztr_pkg::DEPTH_MIN;
				fb_wr.tidx  = ztr_pkg::TIDX_NONE;
			end
			ztr_pkg::ST_IDLE: begin
				fb_wr.we     = accept && mode_in == ztr_pkg::MODE_BG && pix_in;
				fb_wr.col_en = 1'b1;
				fb_wr.addr   = pix_addr;
				fb_wr.depth  = ztr_pkg::DEPTH_MIN;
				fb_wr.tidx   = ztr_pkg::TIDX_NONE;
				fb_wr.col    = {chan_c, chan_b, chan_a};
				fb_rd.re     = accept && mode_in == ztr_pkg::MODE_READ;
				fb_rd.addr   = pix_addr;
			end
			ztr_pkg::ST_MEM_RD: begin
				fb_rd.re   = 1'b1;
				fb_rd.addr = tri_addr;
			end
			ztr_pkg::ST_PIX_WR: begin
				fb_wr.we     = 1'b1;
				fb_wr.col_en = cwe_q;
				fb_wr.addr   = tri_addr;
				fb_wr.depth  = z_q;
				fb_wr.tidx   = ztr_pkg::TIDX_W'(count_q);
				fb_wr.col    = col_q;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ztr_pkg::ST_CLEAR;
			issued_q  <= 1'b0;
			clr_q     <= '0;
			phase_q   <= 2'd0;
			count_q   <= '0;
			out_valid <= 1'b0;
			width_q   <= 9'd256;
			height_q  <= 9'd256;
			chan_q    <= 2'd3;
			flat_q    <= 1'b0;
			cwe_q     <= 1'b1;
		end else begin
			state_q <= state_d;
			if (mdu_ctl.start) begin
				issued_q <= 1'b1;
			end else if (mdu_done) begin
				issued_q <= 1'b0;
			end
			if (state_q == ztr_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept) begin
				if (mode_in == ztr_pkg::MODE_FRAME) begin
					phase_q <= 2'd0;
					count_q <= '0;
				end else if (mode_in == ztr_pkg::MODE_VERT && phase_q != 2'd2) begin
					phase_q <= phase_q + 2'd1;
				end
			end
			if (state_q == ztr_pkg::ST_TRI_END) begin
				phase_q <= 2'd0;
				count_q <= (32'(count_q) == ztr_pkg::MAX_TRIANGLES - 1) ? '0
				                                                         : count_q + 1'b1;
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					ztr_pkg::CFG_WIDTH:    width_q  <= cfg_data;
					ztr_pkg::CFG_HEIGHT:   height_q <= cfg_data;
					ztr_pkg::CFG_CHANNELS: chan_q   <= cfg_data[1:0];
					ztr_pkg::CFG_FLAT:     flat_q   <= cfg_data[0];
					ztr_pkg::CFG_CWE:      cwe_q    <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	// vertex, triangle and result payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				vx_q[i] <= '0;
				vy_q[i] <= '0;
				vz_q[i] <= '0;
				vc_q[i] <= '0;
			end
		end else begin
			if (accept && mode_in == ztr_pkg::MODE_VERT) begin
				vx_q[phase_q] <= vert_x;
				vy_q[phase_q] <= vert_y;
				vz_q[phase_q] <= vert_z;
				vc_q[phase_q] <= {chan_c, chan_b, chan_a};
			end
			if (accept && mode_in == ztr_pkg::MODE_READ) begin
				rd_in_q <= pix_in;
			end
			if (out_load) begin
				read_depth    <= rd_in_q ? rd_depth : $signed(ztr_pkg::DEPTH_MIN);
				read_chan_a   <= rd_in_q ? rd_col[7:0] : 8'd0;
				read_chan_b   <= rd_in_q ? rd_col[15:8] : 8'd0;
				read_chan_c   <= rd_in_q ? rd_col[23:16] : 8'd0;
				read_triangle <= rd_in_q ? $signed(rd_tidx) : $signed(ztr_pkg::TIDX_NONE);
			end
			unique case (state_q)
				ztr_pkg::ST_SETUP: begin
					e0a_q  <= 17'(vy_q[1]) - 17'(vy_q[2]);
					e0b_q  <= 17'(vx_q[2]) - 17'(vx_q[1]);
					e1a_q  <= 17'(vy_q[2]) - 17'(vy_q[0]);
					e1b_q  <= 17'(vx_q[0]) - 17'(vx_q[2]);
					dy02_q <= 17'(vy_q[0]) - 17'(vy_q[2]);
					// ceil of the minimum, floor of the maximum, then clamp to the frame
					x0_q <= ztr_pkg::XW'(clampc((18'(mnx) + 18'sd15) >>> 4,
					                            $signed(18'(weff)) - 18'sd1));
					x1_q <= ztr_pkg::XW'(clampc(18'(mxx) >>> 4, $signed(18'(weff)) - 18'sd1));
					y0_q <= ztr_pkg::YW'(clampc((18'(mny) + 18'sd15) >>> 4,
					                            $signed(18'(heff)) - 18'sd1));
					y1_q <= ztr_pkg::YW'(clampc(18'(mxy) >>> 4, $signed(18'(heff)) - 18'sd1));
				end
				ztr_pkg::ST_DET_B: begin
					if (mdu_done) begin
						neg_q <= mdu_res[DW-1];
						det_q <= mdu_res[DW-1] ? -res_n : res_n;
					end
				end
				ztr_pkg::ST_DET_CHK: begin
					x_q <= x0_q;
					y_q <= y0_q;
				end
				ztr_pkg::ST_N0_B: if (mdu_done) n0_q <= neg_q ? -res_n : res_n;
				ztr_pkg::ST_N1_B: if (mdu_done) n1_q <= neg_q ? -res_n : res_n;
				ztr_pkg::ST_COVER: n2_q <= n2_c;
				ztr_pkg::ST_ZDIV: if (mdu_done) z_q <= mdu_res[31:0];
				ztr_pkg::ST_MEM_CMP: begin
					col_q <= flat_q ? flat_col : rd_col;
					ch_q  <= 2'd0;
				end
				ztr_pkg::ST_CDIV: begin
					if (mdu_done) begin
						col_q[{ch_q, 3'b000} +: 8] <= mdu_res[7:0];
						ch_q <= ch_q + 2'd1;
					end
				end
				ztr_pkg::ST_PIX_NEXT: begin
					if (x_q == x1_q) begin
						x_q <= x0_q;
						y_q <= y_q + 1'b1;
					end else begin
						x_q <= x_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	ztr_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mdu_ctl),
		.a      (mdu_a),
		.b      (mdu_b),
		.acc    (mdu_acc),
		.busy   (mdu_busy),
		.done   (mdu_done),
		.res    (mdu_res)
	);

	ztr_fbuf u_fbuf (
		.clk      (clk),
		.wr       (fb_wr),
		.rd       (fb_rd),
		.rd_depth (rd_depth),
		.rd_tidx  (rd_tidx),
		.rd_col   (rd_col)
	);

	`ZTR_ASSERT(a_start_idle, mdu_ctl.start |-> !mdu_busy, "math unit started while busy")
	`ZTR_ASSERT(a_done_owned, mdu_done |-> issued_q, "math result with no operation pending")
	`ZTR_ASSERT(a_depth_win, (fb_wr.we && state_q == ztr_pkg::ST_PIX_WR) |-> (z_q > rd_depth), "pixel written without winning depth test")
	`ZTR_NEVER(a_phase_range, phase_q == 2'd3, "vertex phase out of range")
endmodule
`default_nettype wire

// File: dv/zbuffer_triangle_rasterizer_core_tb.sv
// self-checking testbench for the z-buffer triangle rasterizer core
`default_nettype none
module zbuffer_triangle_rasterizer_core_tb;
	import ztr_pkg::*;

	typedef struct {
		logic [1:0]         mode;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [23:0] vz;
		logic [7:0]         ca;
		logic [7:0]         cb;
		logic [7:0]         cc;
		logic [7:0]         px;
		logic [7:0]         py;
	} beat_t;

	typedef struct {
		logic signed [31:0] depth;
		logic [7:0]         ca;
		logic [7:0]         cb;
		logic [7:0]         cc;
		logic [16:0]        tri_idx;
	} pixel_read_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] mode = '0;
	logic signed [15:0] vert_x = '0;
	logic signed [15:0] vert_y = '0;
	logic signed [23:0] vert_z = '0;
	logic [7:0] chan_a = '0, chan_b = '0, chan_c = '0, pixel_x = '0, pixel_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] read_depth;
	logic [7:0] read_chan_a, read_chan_b, read_chan_c;
	logic signed [16:0] read_triangle;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [8:0] cfg_data = '0;

	always #2 clk = ~clk;

	zbuffer_triangle_rasterizer_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z),
		.chan_a(chan_a), .chan_b(chan_b), .chan_c(chan_c),
		.pixel_x(pixel_x), .pixel_y(pixel_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.read_depth(read_depth), .read_chan_a(read_chan_a), .read_chan_b(read_chan_b),
		.read_chan_c(read_chan_c), .read_triangle(read_triangle),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow of the frame stores, updated in beat order as beats are queued
	int          depth_mem [0:NPIX-1];
	logic [23:0] color_mem [0:NPIX-1];
	int          tri_mem   [0:NPIX-1];
	logic [2:0]  color_known [0:NPIX-1];   // per-channel "has been written" flags

	// held vertices, phase and count of the triangle assembler
	longint      held_x [0:1];
	longint      held_y [0:1];
	longint      held_z [0:1];
	logic [23:0] held_col [0:1];
	int          vtx_phase;
	int          tri_count;

	// shadow of the registers, raw as written
	int sh_width, sh_height, sh_chans;
	bit sh_flat, sh_cwe;

	beat_t       pending_beats [$];
	pixel_read_t expected_reads [$];

	int  errors;
	int  beats_sent, reads_checked, triangles_drawn;
	bit  no_idle;       // phase runs without gaps or stalls
	bit  armed_hold;    // one long receiver hold-off still to do

	function automatic longint floor_div(longint n, longint d);
		longint q;
		q = n / d;
		if (n % d != 0 && n < 0)
			q = q - 1;
		return q;
	endfunction

	// nearest, ties toward plus infinity
	function automatic longint round_div(longint n, longint d);
		return floor_div(2 * n + d, 2 * d);
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic void draw_triangle(longint x2, longint y2, longint z2, logic [23:0] c2);
		longint vx [3], vy [3], vz [3];
		logic [23:0] col [3];
		longint det, sg, w, h, nch, mnx, mxx, mny, mxy, x0, x1, y0, y1;
		longint n0, n1, n2, z, cv, ppx, ppy;
		int idx;
		logic [23:0] cw;
		logic [7:0] v;
		vx[0] = held_x[0]; vy[0] = held_y[0]; vz[0] = held_z[0]; col[0] = held_col[0];
		vx[1] = held_x[1]; vy[1] = held_y[1]; vz[1] = held_z[1]; col[1] = held_col[1];
		vx[2] = x2; vy[2] = y2; vz[2] = z2; col[2] = c2;
		det = (vy[1] - vy[2]) * (vx[0] - vx[2]) + (vx[2] - vx[1]) * (vy[0] - vy[2]);
		if (det == 0)
			return;   // degenerate: no coverage, index still consumed
		sg = det < 0 ? -1 : 1;
		det = det * sg;
		w = clip(sh_width, 1, MAX_WIDTH);
		h = clip(sh_height, 1, MAX_HEIGHT);
		nch = clip(sh_chans, 1, CH_MAX);
		mnx = vx[0]; mxx = vx[0]; mny = vy[0]; mxy = vy[0];
		for (int i = 1; i < 3; i++) begin
			if (vx[i] < mnx) mnx = vx[i];
			if (vx[i] > mxx) mxx = vx[i];
			if (vy[i] < mny) mny = vy[i];
			if (vy[i] > mxy) mxy = vy[i];
		end
		x0 = clip(-floor_div(-mnx, 16), 0, w - 1);
		x1 = clip(floor_div(mxx, 16), 0, w - 1);
		y0 = clip(-floor_div(-mny, 16), 0, h - 1);
		y1 = clip(floor_div(mxy, 16), 0, h - 1);
		for (longint y = y0; y <= y1; y++) begin
			for (longint x = x0; x <= x1; x++) begin
				ppx = x * 16;
				ppy = y * 16;
				n0 = sg * ((vy[1] - vy[2]) * (ppx - vx[2]) + (vx[2] - vx[1]) * (ppy - vy[2]));
				n1 = sg * ((vy[2] - vy[0]) * (ppx - vx[2]) + (vx[0] - vx[2]) * (ppy - vy[2]));
				n2 = det - n0 - n1;
				if (n0 < 0 || n1 < 0 || n2 < 0)
					continue;
				z = round_div(n0 * vz[0] + n1 * vz[1] + n2 * vz[2], det);
				idx = int'(y) * MAX_WIDTH + int'(x);
				if (longint'(depth_mem[idx]) < z) begin
					depth_mem[idx] = int'(z);
					if (sh_cwe) begin
						cw = color_mem[idx];
						for (int c = 0; c < nch; c++) begin
							if (sh_flat)
								v = col[0][8*c +: 8];
							else begin
								cv = round_div(n0 * longint'(col[0][8*c +: 8])
									+ n1 * longint'(col[1][8*c +: 8])
									+ n2 * longint'(col[2][8*c +: 8]), det);
								v = cv[7:0];
							end
							cw[8*c +: 8] = v;
							color_known[idx][c] = 1'b1;
						end
						color_mem[idx] = cw;
					end
					tri_mem[idx] = tri_count;
				end
			end
		end
	endfunction

	// apply one beat to the shadow state, in the order the core sees it
	function automatic void predict_beat(beat_t b);
		int idx;
		pixel_read_t r;
		idx = int'(b.py) * MAX_WIDTH + int'(b.px);
		case (b.mode)
			MODE_BG: begin
				color_mem[idx] = {b.cc, b.cb, b.ca};
				color_known[idx] = 3'b111;
				depth_mem[idx] = int'(DEPTH_MIN);
				tri_mem[idx] = -1;
			end
			MODE_VERT: begin
				if (vtx_phase < 2) begin
					held_x[vtx_phase] = b.vx;
					held_y[vtx_phase] = b.vy;
					held_z[vtx_phase] = b.vz;
					held_col[vtx_phase] = {b.cc, b.cb, b.ca};
					vtx_phase++;
				end else begin
					draw_triangle(b.vx, b.vy, b.vz, {b.cc, b.cb, b.ca});
					vtx_phase = 0;
					triangles_drawn++;
					tri_count = (tri_count + 1) % MAX_TRIANGLES;
				end
			end
			MODE_FRAME: begin
				tri_count = 0;
				vtx_phase = 0;
			end
			default: begin
				r.depth = depth_mem[idx];
				r.ca = color_mem[idx][7:0];
				r.cb = color_mem[idx][15:8];
				r.cc = color_mem[idx][23:16];
				r.tri_idx = tri_mem[idx][16:0];
				expected_reads.push_back(r);
			end
		endcase
	endfunction

	function automatic beat_t noise_beat(logic [1:0] m);
		beat_t b;
		b.mode = m;
		b.vx = $urandom; b.vy = $urandom; b.vz = $urandom;
		b.ca = $urandom; b.cb = $urandom; b.cc = $urandom;
		b.px = $urandom; b.py = $urandom;
		return b;
	endfunction

	function automatic void queue_beat(beat_t b);
		predict_beat(b);
		pending_beats.push_back(b);
		beats_sent++;
	endfunction

	function automatic void queue_bg(int x, int y, logic [23:0] col);
		beat_t b;
		b = noise_beat(MODE_BG);
		b.px = x; b.py = y;
		{b.cc, b.cb, b.ca} = col;
		queue_beat(b);
	endfunction

	// never read back a colour channel that nothing has written yet
	function automatic void queue_read(int x, int y);
		beat_t b;
		if (color_known[y * MAX_WIDTH + x] != 3'b111)
			queue_bg(x, y, $urandom);
		b = noise_beat(MODE_READ);
		b.px = x; b.py = y;
		queue_beat(b);
	endfunction

	function automatic void queue_vertex(longint x, longint y, longint z, logic [23:0] col);
		beat_t b;
		b = noise_beat(MODE_VERT);
		b.vx = x; b.vy = y; b.vz = z;
		{b.cc, b.cb, b.ca} = col;
		queue_beat(b);
	endfunction

	// small triangle near pixel (bx,by); spread is in sixteenths of a pixel
	function automatic void queue_small_tri(int bx, int by, int spread);
		longint z;
		for (int i = 0; i < 3; i++) begin
			z = ($urandom_range(0, 7) == 0) ? longint'($signed(24'($urandom)))
				: longint'($urandom_range(0, 4000)) - 2000;
			queue_vertex(bx * 16 + $urandom_range(0, 2 * spread) - spread,
				by * 16 + $urandom_range(0, 2 * spread) - spread, z, $urandom);
		end
	endfunction

	// random mix: mostly complete triangles, with background writes, reads, stray vertices and frame restarts
	function automatic void queue_random_phase(int n, bit wide_coords);
		int start, r, x, y;
		start = beats_sent;
		while (beats_sent - start < n) begin
			r = $urandom_range(0, 99);
			x = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 9);
			y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 9);
			if (r < 45) begin
				if (wide_coords)
					for (int i = 0; i < 3; i++)
						queue_vertex($signed(16'($urandom)), $signed(16'($urandom)),
							$signed(24'($urandom)), $urandom);
				else
					queue_small_tri($urandom_range(0, 9), $urandom_range(0, 9),
						$urandom_range(4, 24));
			end else if (r < 60)
				queue_bg(x, y, $urandom);
			else if (r < 90)
				queue_read(x, y);
			else if (r < 94)
				queue_beat(noise_beat(MODE_FRAME));
			else if (r < 97)
				queue_vertex($urandom_range(0, 160), $urandom_range(0, 160),
					$signed(24'($urandom)), $urandom);
			else
				queue_bg($urandom_range(0, 255), $urandom_range(0, 255), $urandom);
		end
	endfunction

	// stimulus driver: one beat in flight, random gap before each next beat unless no_idle is set
	int send_gap = 0;
	always @(posedge clk) begin : beat_driver
		beat_t b;
		if (arst_n && !(in_valid && !in_ready)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_beats.size() > 0) begin
				b = pending_beats.pop_front();
				mode <= b.mode; vert_x <= b.vx; vert_y <= b.vy; vert_z <= b.vz;
				chan_a <= b.ca; chan_b <= b.cb; chan_c <= b.cc;
				pixel_x <= b.px; pixel_y <= b.py;
				in_valid <= 1'b1;
				send_gap <= no_idle ? 0 : $urandom_range(0, 6);
			end else
				in_valid <= 1'b0;
		end
	end

	// result monitor with random back-pressure and one long hold-off
	int stall_left = 0;
	int hold_left = 0;
	always @(posedge clk) begin : read_monitor
		pixel_read_t e;
		int s;
		bit took;
		took = out_valid && out_ready;
		s = 0;
		if (took) begin
			reads_checked++;
			if (expected_reads.size() == 0) begin
				$error("read result with nothing outstanding");
				errors++;
			end else begin
				e = expected_reads.pop_front();
				if (read_depth !== e.depth) begin
					$error("read_depth exp %0d got %0d", e.depth, read_depth);
					errors++;
				end
				if (read_chan_a !== e.ca) begin
					$error("read_chan_a exp %0d got %0d", e.ca, read_chan_a);
					errors++;
				end
				if (read_chan_b !== e.cb) begin
					$error("read_chan_b exp %0d got %0d", e.cb, read_chan_b);
					errors++;
				end
				if (read_chan_c !== e.cc) begin
					$error("read_chan_c exp %0d got %0d", e.cc, read_chan_c);
					errors++;
				end
				if (read_triangle !== $signed(e.tri_idx)) begin
					$error("read_triangle exp %0d got %0d", $signed(e.tri_idx), read_triangle);
					errors++;
				end
			end
			s = no_idle ? 0 : $urandom_range(0, 6);
		end
		if (!arst_n)
			out_ready <= 1'b0;
		else if (armed_hold && took && reads_checked >= 60) begin
			// hold off long enough that the core backs up and stalls its input
			armed_hold <= 1'b0;
			hold_left <= 600;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= (hold_left == 1);
		end else if (took) begin
			stall_left <= s;
			out_ready <= (s == 0);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= (stall_left == 1);
		end else
			out_ready <= 1'b1;
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[8:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_WIDTH:    sh_width = val & 9'h1FF;
			CFG_HEIGHT:   sh_height = val & 9'h1FF;
			CFG_CHANNELS: sh_chans = val & 3;
			CFG_FLAT:     sh_flat = val[0];
			default:      sh_cwe = val[0];
		endcase
	endtask

	task automatic write_all_regs(int w, int h, int ch, int flat, int cwe);
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		write_reg(CFG_CHANNELS, ch);
		write_reg(CFG_FLAT, flat);
		write_reg(CFG_CWE, cwe);
	endtask

	// a trailing read cannot be taken before any triangle ahead of it is finished,
	// so its result arriving means the core is idle
	task automatic drain;
		queue_read(0, 0);
		while (pending_beats.size() > 0 || in_valid || expected_reads.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < NPIX; i++) begin
			depth_mem[i] = int'(DEPTH_MIN);
			tri_mem[i] = -1;
			color_mem[i] = '0;
			color_known[i] = '0;
		end
		held_x = '{0, 0}; held_y = '{0, 0}; held_z = '{0, 0}; held_col = '{0, 0};
		vtx_phase = 0; tri_count = 0;
		sh_width = 256; sh_height = 256; sh_chans = 3; sh_flat = 0; sh_cwe = 1;
		errors = 0; beats_sent = 0; reads_checked = 0; triangles_drawn = 0;
		no_idle = 0; armed_hold = 1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, corners, degenerate triangle, frame restart
		queue_bg(0, 0, 24'h000000);
		queue_bg(255, 255, 24'hFFFFFF);
		queue_bg(1, 1, 24'h123456);
		queue_read(0, 0);
		queue_read(255, 255);
		queue_vertex(0, 0, 24'sh7FFFFF, 24'hFF0000);
		queue_vertex(48, 0, -24'sh800000, 24'h00FF00);
		queue_vertex(0, 48, 0, 24'h0000FF);
		queue_read(1, 1);
		queue_read(0, 0);
		queue_vertex(16, 16, 100, 24'h111111);     // collinear: no pixels
		queue_vertex(32, 32, 100, 24'h222222);
		queue_vertex(48, 48, 100, 24'h333333);
		queue_beat(noise_beat(MODE_FRAME));
		queue_vertex(4080, 4080, 500, 24'hABCDEF); // corner pixel (255,255)
		queue_vertex(4064, 4080, 500, 24'hABCDEF);
		queue_vertex(4080, 4064, 500, 24'hABCDEF);
		queue_read(255, 255);
		queue_read(2, 2);
		drain();

		// single-pixel frame, vertices at the coordinate extremes
		write_all_regs(0, 1, 0, 1, 1);
		queue_vertex(-32768, -32768, -8388608, 24'h0F0F0F);
		queue_vertex(32767, -32768, 8388607, 24'hF0F0F0);
		queue_vertex(-32768, 32767, 0, 24'h5A5A5A);
		queue_read(0, 0);
		queue_read(1, 0);
		drain();

		// random phases under a range of register settings
		write_all_regs(256, 256, 3, 0, 1);
		queue_random_phase(150, 0);
		drain();
		write_all_regs(4, 3, 1, 1, 1);
		queue_random_phase(130, 0);
		drain();
		write_all_regs(1, 0, 2, 0, 0);
		queue_random_phase(110, 0);
		drain();
		write_all_regs(511, 300, 0, 1, 1);
		queue_random_phase(140, 0);
		drain();
		write_all_regs(2, 2, 3, 0, 1);
		queue_random_phase(150, 1);
		drain();
		write_all_regs(256, 256, 2, 0, 1);
		queue_random_phase(140, 0);
		drain();
		write_all_regs(256, 256, 3, 1, 0);
		queue_random_phase(140, 0);
		drain();
		no_idle = 1;
		write_all_regs(256, 256, 3, 0, 1);
		queue_random_phase(140, 0);
		drain();

		$display("sent %0d beats, drew %0d triangles, checked %0d pixel reads",
			beats_sent, triangles_drawn, reads_checked);
		$display("register settings covered frame sizes 1..511, 0..3 channels, flat/interp");
		if (errors == 0 && expected_reads.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20000000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// File: sim.f
+incdir+hdl
hdl/ztr_pkg.sv
hdl/ztr_mdu.sv
hdl/ztr_fbuf.sv
hdl/zbuffer_triangle_rasterizer_core.sv
dv/zbuffer_triangle_rasterizer_core_tb.sv
